[hw/rtl/cpt_pkg.sv]
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the Chebyshev point thinning block.
// ----------------------------------------------------------------------------
package cpt_pkg;

  localparam int COORD_W        = 32;
  localparam int RADIUS_W       = 10;
  localparam int COUNT_OUT_W    = 9;
  localparam int MAX_POINTS_DEF = 256;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd10;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } cpt_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctrl_t;

  typedef struct packed {
    logic hit_valid;
    logic hit;
  } match_stat_t;

endpackage

[hw/rtl/chebyshev_point_thinning.sv]
// ----------------------------------------------------------------------------
// chebyshev_point_thinning
// Greedy spatial suppression of 2-D points against a list of kept points.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid in_ready cmd point_x point_y    | in
//   out     | out_valid out_ready accepted list_full   | out
//           | accepted_count                           |
//   cfg     | cfg_wr_en cfg_wr_data (box_radius)       | in
//
// A point word reads the kept store one entry per cycle, stopping at the
// first close entry. A clear word goes straight to the finish step.
// Reset empties the list and sets box_radius to 10; no clearing pass.
// A new word is taken while a result waits; a result stalled on out_ready
// holds the finish step and the store update until the slot frees.
// ----------------------------------------------------------------------------
module chebyshev_point_thinning #(
  parameter int MAX_POINTS = cpt_pkg::MAX_POINTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 cmd,
  input  logic signed [cpt_pkg::COORD_W-1:0]   point_x,
  input  logic signed [cpt_pkg::COORD_W-1:0]   point_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 accepted,
  output logic                                 list_full,
  output logic [cpt_pkg::COUNT_OUT_W-1:0]      accepted_count,
  input  logic                                 cfg_wr_en,
  input  logic [cpt_pkg::RADIUS_W-1:0]         cfg_wr_data
);
  import cpt_pkg::*;

  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  cpt_state_t st, st_next;
  logic [CNT_W-1:0]          idx, idx_next;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic                      clr_q, clr_next;
  logic                      hit_q, hit_next;
  logic signed [COORD_W-1:0] px_q;
  logic signed [COORD_W-1:0] py_q;
  logic [RADIUS_W-1:0]       box_radius;

  mem_ctrl_t   ctrl;
  match_stat_t stat;

  logic                   load;
  logic                   res_acc;
  logic                   res_full;
  logic                   issuing;

  cpt_match #(
    .MAX_POINTS (MAX_POINTS),
    .ADDR_W     (ADDR_W)
  ) u_match (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_addr (idx[ADDR_W-1:0]),
    .wr_addr (cnt[ADDR_W-1:0]),
    .px      (px_q),
    .py      (py_q),
    .radius  (box_radius),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      box_radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      box_radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      idx   <= '0;
      cnt   <= '0;
      clr_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      st    <= st_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
      clr_q <= clr_next;
      hit_q <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px_q <= point_x;
      py_q <= point_y;
    end
  end

  always_comb begin
    st_next    = st;
    idx_next   = idx;
    cnt_next   = cnt;
    clr_next   = clr_q;
    hit_next   = hit_q;
    in_ready   = 1'b0;
    ctrl.rd_en = 1'b0;
    ctrl.wr_en = 1'b0;
    load       = 1'b0;
    res_acc    = 1'b0;
    res_full   = 1'b0;
    issuing    = idx < cnt;
    case (st)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          idx_next = '0;
          hit_next = 1'b0;
          clr_next = (cmd == CMD_CLEAR);
          st_next  = (cmd == CMD_CLEAR) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          hit_next = 1'b1;
          st_next  = ST_FINISH;
        end else if (issuing) begin
          ctrl.rd_en = 1'b1;
          idx_next   = CNT_W'(idx + 1'b1);
        end else begin
          st_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load    = 1'b1;
          st_next = ST_IDLE;
          if (clr_q) begin
            cnt_next = '0;
          end else if (!hit_q) begin
            if (cnt < CNT_MAX) begin
              ctrl.wr_en = 1'b1;
              cnt_next   = CNT_W'(cnt + 1'b1);
              res_acc    = 1'b1;
            end else begin
              res_full = 1'b1;
            end
          end
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted       <= res_acc;
      list_full      <= res_full;
      accepted_count <= COUNT_OUT_W'(cnt_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_MAX)
    else $error("kept count above capacity");

  a_read_in_list: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_en |-> (idx < cnt) && (st == ST_SCAN))
    else $error("store read outside kept list");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_en |=> (cnt == CNT_W'($past(cnt) + 1'b1)) && out_valid && accepted)
    else $error("store write without count step and accepted result");

  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && list_full))
    else $error("accepted and list_full both set");

endmodule

[hw/rtl/cpt_match.sv]
// ----------------------------------------------------------------------------
// cpt_match
// Kept-point store with one registered read port and a Chebyshev box
// comparator on the read data.
// ----------------------------------------------------------------------------
module cpt_match #(
  parameter int MAX_POINTS = cpt_pkg::MAX_POINTS_DEF,
  parameter int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  cpt_pkg::mem_ctrl_t                   ctrl,
  input  logic [ADDR_W-1:0]                    rd_addr,
  input  logic [ADDR_W-1:0]                    wr_addr,
  input  logic signed [cpt_pkg::COORD_W-1:0]   px,
  input  logic signed [cpt_pkg::COORD_W-1:0]   py,
  input  logic [cpt_pkg::RADIUS_W-1:0]         radius,
  output cpt_pkg::match_stat_t                 stat
);
  import cpt_pkg::*;

  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rd_data;
  logic                 rd_valid;

  logic signed [COORD_W:0] kx;
  logic signed [COORD_W:0] ky;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] rpos;
  logic signed [COORD_W:0] rneg;
  logic                    near_x;
  logic                    near_y;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= {px, py};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_en;
    end
  end

  always_comb begin
    kx     = {rd_data[2*COORD_W-1], rd_data[2*COORD_W-1:COORD_W]};
    ky     = {rd_data[COORD_W-1], rd_data[COORD_W-1:0]};
    dx     = {px[COORD_W-1], px} - kx;
    dy     = {py[COORD_W-1], py} - ky;
    rpos   = $signed({{(COORD_W+1-RADIUS_W){1'b0}}, radius});
    rneg   = -rpos;
    near_x = (dx <= rpos) && (dx >= rneg);
    near_y = (dy <= rpos) && (dy >= rneg);
  end

  assign stat.hit_valid = rd_valid;
  assign stat.hit       = rd_valid && near_x && near_y;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for chebyshev_point_thinning. A scoreboard class keeps
// its own copy of the kept-point list and box_radius, predicts accepted,
// list_full and accepted_count for every word taken at the input, and checks
// each result word in order. A short directed part covers the axis
// boundaries, extreme coordinates, clears and the radius extremes. It is
// followed by random surveys: clustered points around a random center,
// boundary hits next to earlier points, noise and stray clears, and one
// survey that fills the list. Both sides stall at random, the receiver holds
// off once for a long stretch, and box_radius changes between surveys.
// ----------------------------------------------------------------------------
module testbench;
  import cpt_pkg::*;

  localparam int KEEP_DEPTH   = MAX_POINTS_DEF;
  localparam int RADIUS_MAX   = (1 << RADIUS_W) - 1;
  localparam int COORD_MAX    = int'(32'h7FFF_FFFF);
  localparam int COORD_MIN    = int'(32'h8000_0000);
  localparam int ITEM_GOAL    = 850;
  localparam int IDLE_PCT     = 23;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic                   acc;
    logic                   full;
    logic [COUNT_OUT_W-1:0] count;
  } verdict_t;

  class thinning_scoreboard;
    longint               kept_x[KEEP_DEPTH];
    longint               kept_y[KEEP_DEPTH];
    int                   kept_num;
    logic [RADIUS_W-1:0]  radius;
    verdict_t             verdict_q[$];
    int                   errors;

    function new();
      kept_num = 0;
      radius   = RADIUS_RESET;
      errors   = 0;
    endfunction

    function void set_radius(logic [RADIUS_W-1:0] val);
      radius = val;
    endfunction

    function longint axis_dist(longint a, longint b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function void note_input(logic c, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y);
      longint   px;
      longint   py;
      longint   lim;
      bit       near;
      verdict_t v;
      v = '0;
      if (c == CMD_CLEAR) begin
        kept_num = 0;
      end else begin
        px   = x;
        py   = y;
        lim  = radius;
        near = 1'b0;
        for (int i = 0; i < kept_num && !near; i++) begin
          if (axis_dist(px, kept_x[i]) <= lim && axis_dist(py, kept_y[i]) <= lim) begin
            near = 1'b1;
          end
        end
        if (!near) begin
          if (kept_num < KEEP_DEPTH) begin
            kept_x[kept_num] = px;
            kept_y[kept_num] = py;
            kept_num++;
            v.acc = 1'b1;
          end else begin
            v.full = 1'b1;
          end
        end
      end
      v.count = kept_num[COUNT_OUT_W-1:0];
      verdict_q = {verdict_q, v};
    endfunction

    function void check_result(logic a, logic f, logic [COUNT_OUT_W-1:0] n);
      verdict_t want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: accepted=%0b list_full=%0b count=%0d",
                 $time, a, f, n);
        return;
      end
      want = verdict_q.pop_front();
      if (a !== want.acc) begin
        errors++;
        $display("%0t: accepted mismatch: expected %0b, actual %0b", $time, want.acc, a);
      end
      if (f !== want.full) begin
        errors++;
        $display("%0t: list_full mismatch: expected %0b, actual %0b", $time, want.full, f);
      end
      if (n !== want.count) begin
        errors++;
        $display("%0t: accepted_count mismatch: expected %0d, actual %0d",
                 $time, want.count, n);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      cmd = CMD_CLEAR;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      accepted;
  logic                      list_full;
  logic [COUNT_OUT_W-1:0]    accepted_count;
  logic                      cfg_wr_en = 1'b0;
  logic [RADIUS_W-1:0]       cfg_wr_data = '0;

  thinning_scoreboard sb = new();
  int words_sent   = 0;
  int stall_cycles = 0;
  int cur_radius   = RADIUS_RESET;
  bit steady       = 1'b0;
  bit hold_req     = 1'b0;

  chebyshev_point_thinning #(
    .MAX_POINTS(KEEP_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .point_x       (point_x),
    .point_y       (point_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .list_full     (list_full),
    .accepted_count(accepted_count),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin : word_monitor
    if (!rst) begin
      if (cfg_wr_en) begin
        sb.set_radius(cfg_wr_data);
      end
      if (in_valid && in_ready) begin
        sb.note_input(cmd, point_x, point_y);
      end
      if (out_valid && out_ready) begin
        sb.check_result(accepted, list_full, accepted_count);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin : result_sink
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic c, input int x, input int y);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    point_x  <= x;
    point_y  <= y;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_radius(input int val);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val[RADIUS_W-1:0];
    cur_radius  = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_radius();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return RADIUS_MAX;
      2:       return RADIUS_RESET;
      3:       return $urandom_range(1, 15);
      default: return $urandom_range(0, RADIUS_MAX);
    endcase
  endfunction

  // spread points until the list overflows; then near copies and far points
  task automatic run_fill();
    int hx[$];
    int hy[$];
    int px;
    int py;
    int j;
    send_word(CMD_CLEAR, $urandom, $urandom);
    for (int i = 0; i < KEEP_DEPTH + 4; i++) begin
      px = $urandom;
      py = $urandom;
      hx = {hx, px};
      hy = {hy, py};
      send_word(CMD_POINT, px, py);
    end
    for (int i = 0; i < 8; i++) begin
      if (i % 2 == 0) begin
        j = $urandom_range(0, KEEP_DEPTH - 1);
        send_word(CMD_POINT, hx[j], hy[j]);
      end else begin
        send_word(CMD_POINT, $urandom, $urandom);
      end
    end
  endtask

  task automatic run_cluster(input bit long_run);
    int hx[$];
    int hy[$];
    int n;
    int span;
    int base_x;
    int base_y;
    int roll;
    int sel;
    int d;
    int j;
    int px;
    int py;
    n      = long_run ? 48 : $urandom_range(8, 60);
    span   = 2 * cur_radius + 2;
    base_x = $urandom;
    base_y = $urandom;
    if ($urandom_range(0, 7) == 0) begin
      base_x = $urandom_range(0, 1) ? COORD_MAX - 512 : COORD_MIN + 512;
      base_y = $urandom_range(0, 1) ? COORD_MAX - 512 : COORD_MIN + 512;
    end
    if ($urandom_range(0, 9) != 0) begin
      send_word(CMD_CLEAR, $urandom, $urandom);
    end
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        send_word(CMD_CLEAR, $urandom, $urandom);
        continue;
      end
      if (roll < 10) begin
        px = $urandom;
        py = $urandom;
      end else if (roll < 25 && hx.size() > 0) begin
        // just inside or just outside the box of an earlier point
        j   = $urandom_range(0, hx.size() - 1);
        sel = $urandom_range(0, 3);
        d   = sel[0] ? cur_radius : cur_radius + 1;
        if (sel[1]) d = -d;
        if ($urandom_range(0, 1)) begin
          px = hx[j] + d;
          py = hy[j] + int'($urandom_range(0, 2 * cur_radius)) - cur_radius;
        end else begin
          px = hx[j] + int'($urandom_range(0, 2 * cur_radius)) - cur_radius;
          py = hy[j] + d;
        end
      end else begin
        px = base_x + int'($urandom_range(0, 2 * span)) - span;
        py = base_y + int'($urandom_range(0, 2 * span)) - span;
      end
      hx = {hx, px};
      hy = {hy, py};
      send_word(CMD_POINT, px, py);
    end
  endtask

  initial begin : stimulus
    int survey;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset radius, box edges, extreme coordinates, clears
    send_word(CMD_POINT, 0, 0);
    send_word(CMD_POINT, 10, -10);
    send_word(CMD_POINT, 11, 0);
    send_word(CMD_POINT, 0, -11);
    send_word(CMD_POINT, -10, 10);
    send_word(CMD_POINT, COORD_MAX, COORD_MAX);
    send_word(CMD_POINT, COORD_MIN, COORD_MIN);
    send_word(CMD_POINT, COORD_MIN + 10, COORD_MIN + 10);
    send_word(CMD_POINT, COORD_MAX, COORD_MIN);
    send_word(CMD_POINT, COORD_MIN, COORD_MAX);
    send_word(CMD_POINT, COORD_MAX - 10, COORD_MIN + 10);
    send_word(CMD_POINT, COORD_MAX - 11, COORD_MIN);
    send_word(CMD_CLEAR, COORD_MAX, COORD_MIN);
    send_word(CMD_CLEAR, -1, -1);
    send_word(CMD_POINT, -1, -1);
    wait_drained();
    write_radius(0);
    send_word(CMD_POINT, -1, -1);
    send_word(CMD_POINT, 0, -1);
    send_word(CMD_POINT, -1, 0);
    wait_drained();
    write_radius(RADIUS_MAX);
    send_word(CMD_POINT, 1022, 1022);
    send_word(CMD_POINT, 1023, 1023);
    send_word(CMD_POINT, int'(32'h5555_5555), int'(32'hAAAA_AAAA));
    send_word(CMD_CLEAR, int'(32'hAAAA_AAAA), int'(32'h5555_5555));

    // random surveys
    survey = 0;
    while (words_sent < ITEM_GOAL) begin
      wait_drained();
      steady = (survey == 5 || survey == 6);
      if (survey == 2) begin
        write_radius($urandom_range(0, 31));
        run_fill();
      end else begin
        if ($urandom_range(0, 9) < 7) write_radius(pick_radius());
        if (survey == 3) hold_req = 1'b1;
        run_cluster(survey == 3);
      end
      survey++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
